>>> rtl/mcm_pkg.sv
// shared types, codes and constants for the midi control mapper
`default_nettype none

package mcm_pkg;

    // sequencer size and derived widths
    localparam int STEP_COUNT = 8;
    localparam int RUN_LEN    = 2 * STEP_COUNT;
    localparam int RUN_W      = (RUN_LEN > 1) ? $clog2(RUN_LEN) : 1;

    // result kinds
    localparam logic [2:0] KIND_PITCH = 3'd0;
    localparam logic [2:0] KIND_VEL   = 3'd1;
    localparam logic [2:0] KIND_EDIT  = 3'd2;
    localparam logic [2:0] KIND_VMODE = 3'd3;
    localparam logic [2:0] KIND_PLAY  = 3'd4;
    localparam logic [2:0] KIND_RESET = 3'd5;

    // packet code indexes
    localparam logic [3:0] CIN_CC      = 4'd11;
    localparam logic [3:0] CIN_NOTE_ON = 4'd9;

    // controller numbers
    localparam logic [6:0] CC_PITCH_LO = 7'd34;
    localparam logic [6:0] CC_PITCH_HI = 7'd41;
    localparam logic [6:0] CC_VEL_LO   = 7'd50;
    localparam logic [6:0] CC_VEL_HI   = 7'd57;
    localparam logic [6:0] CC_EDIT     = 7'd28;
    localparam logic [6:0] CC_BTN_MODE = 7'd22;
    localparam logic [6:0] CC_BTN_PLAY = 7'd23;
    localparam logic [6:0] CC_BTN_RST  = 7'd24;
    localparam logic [6:0] BUTTON_LEVEL = 7'd64;

    // note numbers
    localparam logic [6:0] NOTE_MODE   = 7'd36;
    localparam logic [6:0] NOTE_PLAY   = 7'd48;
    localparam logic [6:0] NOTE_RST    = 7'd60;
    localparam logic [6:0] NOTE_REROLL = 7'd72;

    // re-roll value ranges
    localparam logic [7:0] PITCH_BASE = 8'd36;
    localparam logic [7:0] PITCH_SPAN = 8'd36;
    localparam logic [7:0] VEL_BASE   = 8'd100;
    localparam logic [7:0] VEL_SPAN   = 8'd156;

    // remainder unit: quarter word times reciprocal of a quarter span,
    // exact for every 30-bit operand
    localparam logic [7:0]  PITCH_SPAN_Q      = PITCH_SPAN >> 2;
    localparam logic [7:0]  VEL_SPAN_Q        = VEL_SPAN >> 2;
    localparam logic [29:0] RECIP_PITCH       = 30'd954437177;  // ceil(2^33 / 9)
    localparam int          RECIP_SHIFT_PITCH = 33;
    localparam logic [29:0] RECIP_VEL         = 30'd881018933;  // ceil(2^35 / 39)
    localparam int          RECIP_SHIFT_VEL   = 35;

    localparam logic [31:0] DEFAULT_SEED = 32'hDEADBEEF;

    typedef struct packed {
        logic       req_type;
        logic [3:0] code_index;
        logic [6:0] controller_or_note;
        logic [6:0] data_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  update_kind;
        logic [2:0]  update_index;
        logic [7:0]  update_value;
        logic [31:0] change_count;
        logic        last_of_run;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic commit;
        logic rng_step;
        logic mod_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic single_hit;
        logic reroll;
        logic out_free;
        logic run_last;
    } status_t;

endpackage

`default_nettype wire

>>> rtl/mcm_ctrl.sv
// controller state machine for the midi control mapper
`default_nettype none

module mcm_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire mcm_pkg::status_t status,
    output mcm_pkg::cmd_t        cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_RNG  = 5'b00100,
        S_MOD  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (status.reroll)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_RNG;
                end
                else if (!status.single_hit || status.out_free)
                begin
                    // a single result waits for the output register to free up
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RNG:
            begin
                cmd.rng_step = 1'b1;
                state_next   = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    state_next = status.run_last ? S_IDLE : S_RNG;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/mcm_dpath.sv
// datapath: decode, sequencer flags, counter, generator, remainder unit, output register
`default_nettype none

module mcm_dpath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mcm_pkg::in_item_t  in_item,
    input  wire logic               cfg_wr_en,
    input  wire logic [31:0]        cfg_wr_data,
    input  wire mcm_pkg::cmd_t      cmd,
    output mcm_pkg::status_t        status,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mcm_pkg::out_item_t      out_item
);

    mcm_pkg::in_item_t  req_reg;
    logic [31:0]        seed_reg;
    logic               vmode_reg;
    logic               play_reg;
    logic [31:0]        count_reg;
    logic [31:0]        rng_reg;
    logic [2:0]         bwh_reg;
    logic [mcm_pkg::RUN_W-1:0]       run_reg;
    logic [31:0]                     word_reg;
    logic [7:0]                      quot_reg;
    logic               out_valid_reg;
    mcm_pkg::out_item_t out_item_reg;

    // decode of the captured request: single result or re-roll
    logic        hit;
    logic        reroll;
    logic [2:0]  kind;
    logic [2:0]  idx;
    logic [7:0]  value;
    logic        vmode_next;
    logic        play_next;
    logic [2:0]  bwh_next;
    logic [6:0]  num;
    logic [6:0]  val;
    logic [6:0]  step;
    logic [2:0]  edit_s;
    logic        high;

    always_comb
    begin
        num        = req_reg.controller_or_note;
        val        = req_reg.data_value;
        high       = (val >= mcm_pkg::BUTTON_LEVEL);
        hit        = 1'b0;
        reroll     = 1'b0;
        kind       = mcm_pkg::KIND_PITCH;
        idx        = 3'd0;
        value      = 8'd0;
        vmode_next = vmode_reg;
        play_next  = play_reg;
        bwh_next   = bwh_reg;
        step       = 7'd0;
        edit_s     = val[6:4];
        if (req_reg.req_type)
        begin
            bwh_next = 3'b000;
        end
        else if (req_reg.code_index == mcm_pkg::CIN_CC)
        begin
            if (num >= mcm_pkg::CC_PITCH_LO && num <= mcm_pkg::CC_PITCH_HI)
            begin
                step = num - mcm_pkg::CC_PITCH_LO;
                if (step < 7'(mcm_pkg::STEP_COUNT))
                begin
                    hit = 1'b1;
                    idx = step[2:0];
                    if (vmode_reg)
                    begin
                        kind  = mcm_pkg::KIND_VEL;
                        value = {val, 1'b0};
                    end
                    else
                    begin
                        kind  = mcm_pkg::KIND_PITCH;
                        value = {1'b0, val};
                    end
                end
            end
            else if (num >= mcm_pkg::CC_VEL_LO && num <= mcm_pkg::CC_VEL_HI)
            begin
                step = num - mcm_pkg::CC_VEL_LO;
                if (step < 7'(mcm_pkg::STEP_COUNT))
                begin
                    hit   = 1'b1;
                    idx   = step[2:0];
                    kind  = mcm_pkg::KIND_VEL;
                    value = {val, 1'b0};
                end
            end
            else if (num == mcm_pkg::CC_EDIT)
            begin
                hit  = 1'b1;
                kind = mcm_pkg::KIND_EDIT;
                // value * 8 >> 7 is the top three bits
                if ({5'd0, edit_s} > 8'(mcm_pkg::STEP_COUNT - 1))
                begin
                    value = 8'(mcm_pkg::STEP_COUNT - 1);
                end
                else
                begin
                    value = {5'd0, edit_s};
                end
            end
            else if (num == mcm_pkg::CC_BTN_MODE)
            begin
                bwh_next[0] = high;
                if (high && !bwh_reg[0])
                begin
                    vmode_next = !vmode_reg;
                    hit        = 1'b1;
                    kind       = mcm_pkg::KIND_VMODE;
                    value      = {7'd0, vmode_next};
                end
            end
            else if (num == mcm_pkg::CC_BTN_PLAY)
            begin
                bwh_next[1] = high;
                if (high && !bwh_reg[1])
                begin
                    play_next = !play_reg;
                    hit       = 1'b1;
                    kind      = mcm_pkg::KIND_PLAY;
                    value     = {7'd0, play_next};
                end
            end
            else if (num == mcm_pkg::CC_BTN_RST)
            begin
                bwh_next[2] = high;
                if (high && !bwh_reg[2])
                begin
                    hit  = 1'b1;
                    kind = mcm_pkg::KIND_RESET;
                end
            end
        end
        else if (req_reg.code_index == mcm_pkg::CIN_NOTE_ON && val != 7'd0)
        begin
            if (num == mcm_pkg::NOTE_MODE)
            begin
                vmode_next = !vmode_reg;
                hit        = 1'b1;
                kind       = mcm_pkg::KIND_VMODE;
                value      = {7'd0, vmode_next};
            end
            else if (num == mcm_pkg::NOTE_PLAY)
            begin
                play_next = !play_reg;
                hit       = 1'b1;
                kind      = mcm_pkg::KIND_PLAY;
                value     = {7'd0, play_next};
            end
            else if (num == mcm_pkg::NOTE_RST)
            begin
                hit  = 1'b1;
                kind = mcm_pkg::KIND_RESET;
            end
            else if (num == mcm_pkg::NOTE_REROLL)
            begin
                reroll = 1'b1;
            end
        end
    end

    // xorshift32, seeding on first use
    logic [31:0] rng_base;
    logic [31:0] xs_a;
    logic [31:0] xs_b;
    logic [31:0] xs_c;

    always_comb
    begin
        if (rng_reg != 32'd0)
        begin
            rng_base = rng_reg;
        end
        else if (seed_reg != 32'd0)
        begin
            rng_base = seed_reg;
        end
        else
        begin
            rng_base = mcm_pkg::DEFAULT_SEED;
        end
        xs_a = rng_base ^ (rng_base << 13);
        xs_b = xs_a ^ (xs_a >> 17);
        xs_c = xs_b ^ (xs_b << 5);
    end

    // x mod 4d is 4 * ((x >> 2) mod d) + x[1:0]; pitch on even results, velocity on odd
    // only the low quotient bits matter since the remainder is below 256
    logic [29:0] recip;
    logic [59:0] product;
    logic [7:0]  quot_next;

    always_comb
    begin
        recip   = run_reg[0] ? mcm_pkg::RECIP_VEL : mcm_pkg::RECIP_PITCH;
        product = 60'(word_reg[31:2]) * 60'(recip);
        if (run_reg[0])
        begin
            quot_next = product[mcm_pkg::RECIP_SHIFT_VEL +: 8];
        end
        else
        begin
            quot_next = product[mcm_pkg::RECIP_SHIFT_PITCH +: 8];
        end
    end

    logic [7:0] span_q;
    logic [7:0] quot_span;
    logic [7:0] rem_q;
    logic [7:0] rem_full;

    always_comb
    begin
        span_q    = run_reg[0] ? mcm_pkg::VEL_SPAN_Q : mcm_pkg::PITCH_SPAN_Q;
        quot_span = quot_reg * span_q;
        rem_q     = word_reg[9:2] - quot_span;
        rem_full  = {rem_q[5:0], word_reg[1:0]};
    end

    logic out_free;
    logic [7:0] run_value;
    logic       run_last;

    assign out_free  = !out_valid_reg || out_ready;
    assign run_last  = (run_reg == mcm_pkg::RUN_W'(mcm_pkg::RUN_LEN - 1));
    assign run_value = run_reg[0] ? (mcm_pkg::VEL_BASE + rem_full)
                                  : (mcm_pkg::PITCH_BASE + rem_full);

    // control registers
    logic        out_valid_next;
    logic [31:0] count_next;

    assign count_next = count_reg + 32'd1;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((cmd.commit && hit) || cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= 32'd0;
            vmode_reg     <= 1'b0;
            play_reg      <= 1'b0;
            count_reg     <= 32'd0;
            rng_reg       <= 32'd0;
            bwh_reg       <= 3'b000;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                seed_reg <= cfg_wr_data;
            end
            if (cmd.commit)
            begin
                vmode_reg <= vmode_next;
                play_reg  <= play_next;
                bwh_reg   <= bwh_next;
                run_reg   <= '0;
                if (hit || reroll)
                begin
                    count_reg <= count_next;
                end
            end
            if (cmd.rng_step)
            begin
                rng_reg <= xs_c;
            end
            if (cmd.emit)
            begin
                run_reg <= run_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= in_item;
        end
        if (cmd.rng_step)
        begin
            word_reg <= xs_c;
        end
        if (cmd.mod_step)
        begin
            quot_reg <= quot_next;
        end
        if (cmd.commit && hit)
        begin
            out_item_reg.update_kind  <= kind;
            out_item_reg.update_index <= idx;
            out_item_reg.update_value <= value;
            out_item_reg.change_count <= count_next;
            out_item_reg.last_of_run  <= 1'b1;
        end
        else if (cmd.emit)
        begin
            out_item_reg.update_kind  <= run_reg[0] ? mcm_pkg::KIND_VEL : mcm_pkg::KIND_PITCH;
            out_item_reg.update_index <= 3'(run_reg >> 1);
            out_item_reg.update_value <= run_value;
            out_item_reg.change_count <= count_reg;
            out_item_reg.last_of_run  <= run_last;
        end
    end

    always_comb
    begin
        status.single_hit = hit;
        status.reroll     = reroll;
        status.out_free   = out_free;
        status.run_last   = run_last;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

>>> rtl/midi_control_mapper_core.sv
// top level of the midi control mapper
//
//  port group   direction  handshake        payload
//  in_*         into core  in_valid/ready   mcm_pkg::in_item_t
//  out_*        from core  out_valid/ready  mcm_pkg::out_item_t
//  cfg_*        into core  cfg_wr_en        rng seed, 32 bits
//
// a request is taken in idle and decoded the next cycle; a single-result request waits in
// decode while the output register is still full, a no-result request does not wait
// a re-roll writes 16 pattern values: each pattern write needs a generator step, a
// reciprocal multiply step and a load of the output register, which waits while it is full
// the output register lets a new request in while the last result is still waiting
// reset clears flags, counter, generator and edge state; there is no clearing pass
`default_nettype none

module midi_control_mapper_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mcm_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mcm_pkg::out_item_t      out_item,
    input  wire logic               cfg_wr_en,
    input  wire logic [31:0]        cfg_wr_data
);

    mcm_pkg::cmd_t    cmd;
    mcm_pkg::status_t status;

    mcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mcm_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_item     (in_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

endmodule

`default_nettype wire
